>>> hdl/tlscs_pkg.sv
`timescale 1ns / 1ps

package tlscs_pkg;

   // Operation codes of an input item.
   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_OFF    = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   // Pending command codes.
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_SET  = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;

   localparam logic [7:0] SET_OPCODE = 8'h11;
   localparam logic [7:0] OFF_OPCODE = 8'h20;
   localparam logic [7:0] OFF_FILL   = 8'h00;

   localparam int FRAME_BITS    = 16;
   localparam int FRAME_CNT_W   = $clog2(FRAME_BITS);
   localparam int QUEUE_DEPTH   = 2;

   // One complete frame, each lane sent MSB first.
   typedef struct packed {
      logic [FRAME_BITS-1:0] lane_a;
      logic [FRAME_BITS-1:0] lane_b;
      logic [FRAME_BITS-1:0] lane_c;
   } frame_type;

endpackage

>>> hdl/three_lane_serial_command_sender.sv
`timescale 1ns / 1ps
// Three-lane serial command sender.
// The req_ channel takes commands: queue set (stores three lane bytes), queue off,
// and update, which turns the pending command into one frame of sixteen pulses.
// The rsp_ channel delivers one transfer per pulse: the three lane levels, MSB
// first, and frame_end on the sixteenth pulse. An update with nothing pending,
// and operation code 3, produce no transfers.
// Throughput: the shifter sends one pulse per cycle unless rsp_ready stalls it,
// and frames follow each other without a gap. Commands are taken one per cycle
// as long as the frame queue (QUEUE_DEPTH entries) has room; req_ready drops
// only while it is full.
// With an idle shifter, the first pulse of a frame goes from the update transfer
// through the queue entry, the shift register and the output register.
// When the receiver holds rsp_ready low, the output register keeps its pulse, the
// shifter pauses, and the queue fills before req_ready falls.
// Reset clears the pending command, the queue and the shifter; no pulse is lost
// or repeated across a stall.
module three_lane_serial_command_sender #(
   parameter int QUEUE_DEPTH = tlscs_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_value_a,
   input  logic [7:0] req_value_b,
   input  logic [7:0] req_value_c,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_lane_a_bit,
   output logic       rsp_lane_b_bit,
   output logic       rsp_lane_c_bit,
   output logic       rsp_frame_end
);
   import tlscs_pkg::*;

   logic      push_valid;
   logic      push_ready;
   frame_type push_frame;
   logic      pop_valid;
   logic      pop_ready;
   frame_type pop_frame;

   tlscs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value_a   (req_value_a),
      .req_value_b   (req_value_b),
      .req_value_c   (req_value_c),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_frame    (push_frame)
   );

   tlscs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_frame  (push_frame),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_frame (pop_frame)
   );

   tlscs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .frame_valid    (pop_valid),
      .frame_ready    (pop_ready),
      .frame          (pop_frame),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_lane_a_bit (rsp_lane_a_bit),
      .rsp_lane_b_bit (rsp_lane_b_bit),
      .rsp_lane_c_bit (rsp_lane_c_bit),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

>>> hdl/tlscs_front.sv
`timescale 1ns / 1ps

module tlscs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [7:0]          req_value_a,
   input  logic [7:0]          req_value_b,
   input  logic [7:0]          req_value_c,
   output logic                push_valid,
   input  logic                push_ready,
   output tlscs_pkg::frame_type push_frame
);
   import tlscs_pkg::*;

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic [7:0] value_a_ff;
   logic [7:0] value_b_ff;
   logic [7:0] value_c_ff;
   logic       take;

   // Every transfer waits for queue room, so an update never has to be held here.
   assign req_ready = push_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      pending_in = pending_ff;
      if (take) begin
         case (req_operation)
            OP_SET:    pending_in = CMD_SET;
            OP_OFF:    pending_in = CMD_OFF;
            OP_UPDATE: pending_in = CMD_NONE;
            default:   pending_in = pending_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= CMD_NONE;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_operation == OP_SET) begin
         value_a_ff <= req_value_a;
         value_b_ff <= req_value_b;
         value_c_ff <= req_value_c;
      end
   end

   assign push_valid = take && req_operation == OP_UPDATE && pending_ff != CMD_NONE;

   always_comb begin
      if (pending_ff == CMD_SET) begin
         push_frame.lane_a = {SET_OPCODE, value_a_ff};
         push_frame.lane_b = {SET_OPCODE, value_b_ff};
         push_frame.lane_c = {SET_OPCODE, value_c_ff};
      end else begin
         push_frame.lane_a = {OFF_OPCODE, OFF_FILL};
         push_frame.lane_b = {OFF_OPCODE, OFF_FILL};
         push_frame.lane_c = {OFF_OPCODE, OFF_FILL};
      end
   end

endmodule

>>> hdl/tlscs_queue.sv
`timescale 1ns / 1ps

module tlscs_queue #(
   parameter int DEPTH = tlscs_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tlscs_pkg::frame_type in_frame,
   output logic                out_valid,
   input  logic                out_ready,
   output tlscs_pkg::frame_type out_frame
);
   import tlscs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_frame = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_frame;
      end
   end

endmodule

>>> hdl/tlscs_back.sv
`timescale 1ns / 1ps

module tlscs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                frame_valid,
   output logic                frame_ready,
   input  tlscs_pkg::frame_type frame,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_lane_a_bit,
   output logic                rsp_lane_b_bit,
   output logic                rsp_lane_c_bit,
   output logic                rsp_frame_end
);
   import tlscs_pkg::*;

   frame_type              shift_ff;
   frame_type              shift_in;
   logic                   active_ff;
   logic                   active_in;
   logic [FRAME_CNT_W-1:0] bit_cnt_ff;
   logic [FRAME_CNT_W-1:0] bit_cnt_in;
   logic                   valid_ff;
   logic                   valid_in;
   logic                   lane_a_ff;
   logic                   lane_b_ff;
   logic                   lane_c_ff;
   logic                   end_ff;
   logic                   advance;
   logic                   last_bit;

   // A pulse moves into the output register whenever that register is free or being taken.
   assign advance     = active_ff && (!valid_ff || rsp_ready);
   assign last_bit    = bit_cnt_ff == FRAME_CNT_W'(FRAME_BITS - 1);
   assign frame_ready = !active_ff || (advance && last_bit);

   always_comb begin
      shift_in   = shift_ff;
      active_in  = active_ff;
      bit_cnt_in = bit_cnt_ff;
      valid_in   = valid_ff && !rsp_ready;
      if (advance) begin
         valid_in        = 1'b1;
         shift_in.lane_a = {shift_ff.lane_a[FRAME_BITS-2:0], 1'b0};
         shift_in.lane_b = {shift_ff.lane_b[FRAME_BITS-2:0], 1'b0};
         shift_in.lane_c = {shift_ff.lane_c[FRAME_BITS-2:0], 1'b0};
         bit_cnt_in      = bit_cnt_ff + 1'b1;
         if (last_bit) begin
            active_in = 1'b0;
         end
      end
      if (frame_valid && frame_ready) begin
         shift_in   = frame;
         active_in  = 1'b1;
         bit_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         valid_ff   <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         active_ff  <= active_in;
         valid_ff   <= valid_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (advance) begin
         lane_a_ff <= shift_ff.lane_a[FRAME_BITS-1];
         lane_b_ff <= shift_ff.lane_b[FRAME_BITS-1];
         lane_c_ff <= shift_ff.lane_c[FRAME_BITS-1];
         end_ff    <= last_bit;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_lane_a_bit = lane_a_ff;
   assign rsp_lane_b_bit = lane_b_ff;
   assign rsp_lane_c_bit = lane_c_ff;
   assign rsp_frame_end  = end_ff;

endmodule
